// ===== rtl/hfr_pkg.sv =====
package hfr_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;

    localparam logic [1:0] CMD_BEGIN  = 2'd0;
    localparam logic [1:0] CMD_ENROLL = 2'd1;
    localparam logic [1:0] CMD_FIRED  = 2'd2;

    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_BEGUN    = 3'd3;
    localparam logic [2:0] ST_DISABLED = 3'd4;

    localparam logic [1:0] CFG_ENABLED   = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_CAPACITY  = 2'd2;

    localparam logic [15:0] THRESHOLD_DEF = 16'd655;
    localparam logic [12:0] CAPACITY_DEF  = 13'd4096;
    localparam int          FLUX_BIT      = 3;

    typedef struct packed {
        logic [23:0] low_site;
        logic [23:0] high_site;
        logic [5:0]  dir;
    } key_t;

    typedef struct packed {
        logic [47:0] origin;
        logic [7:0]  species;
        logic [31:0] steps;
        logic [31:0] fired;
        logic [63:0] flux;
        logic [31:0] barrier;
        logic [31:0] leverage;
        logic [3:0]  triggers;
    } entry_t;

    // floor(rate * dt / 2^32) from p = rate[47:16]*dt and q = rate[15:0]*dt
    function automatic logic [63:0] flux_inc(logic [63:0] p, logic [47:0] q);
        logic [48:0] tail;
        tail = {17'd0, p[15:0], 16'd0} + {1'b0, q};
        return {16'd0, p[63:16]} + {47'd0, tail[48:32]};
    endfunction

    function automatic logic [63:0] sat_add64(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    function automatic logic [31:0] sat_inc32(logic [31:0] a);
        return (a == {32{1'b1}}) ? a : a + 32'd1;
    endfunction

endpackage

// ===== rtl/hfr_mul.sv =====
module hfr_mul (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);

    logic [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= {32'd0, a} * {32'd0, b};
    end

    assign p = p_reg;

endmodule

// ===== rtl/hfr_table.sv =====
module hfr_table #(
    parameter int TABLE_DEPTH = hfr_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic                clk,
    input  logic                key_re,
    input  logic [IDX_W-1:0]    key_raddr,
    output hfr_pkg::key_t       key_rdata,
    input  logic                key_we,
    input  logic [IDX_W-1:0]    key_waddr,
    input  hfr_pkg::key_t       key_wdata,
    input  logic                data_re,
    input  logic [IDX_W-1:0]    data_raddr,
    output hfr_pkg::entry_t     data_rdata,
    input  logic                data_we,
    input  logic [IDX_W-1:0]    data_waddr,
    input  hfr_pkg::entry_t     data_wdata
);

    hfr_pkg::key_t   key_mem [TABLE_DEPTH];
    hfr_pkg::entry_t data_mem [TABLE_DEPTH];
    hfr_pkg::key_t   key_rd_reg;
    hfr_pkg::entry_t data_rd_reg;

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_waddr] <= key_wdata;
        end
        if (key_re)
        begin
            key_rd_reg <= key_mem[key_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[data_waddr] <= data_wdata;
        end
        if (data_re)
        begin
            data_rd_reg <= data_mem[data_raddr];
        end
    end

    assign key_rdata  = key_rd_reg;
    assign data_rdata = data_rd_reg;

endmodule

// ===== rtl/hop_flag_registry.sv =====
// Registry of flagged hops keyed by sorted site pair plus direction, one
// transaction at a time. An enroll or fired item scans the key memory one
// entry per cycle up to the current entry count, stopping early at a match.
// All fixed-point products go through one registered 32x32 multiplier in
// four passes. The result sits in an output register, so the next item may
// be taken while it waits.
module hop_flag_registry #(
    parameter int TABLE_DEPTH = hfr_pkg::TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [23:0] vacancy_site,
    input  logic [23:0] partner_site,
    input  logic [5:0]  dir_index,
    input  logic [7:0]  atom_species,
    input  logic [47:0] origin_coords,
    input  logic [47:0] rate,
    input  logic [31:0] step_dt,
    input  logic signed [31:0] barrier_estimate,
    input  logic [31:0] leverage_value,
    input  logic [3:0]  trigger_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [11:0] entry_index,
    output logic [31:0] enrolled_steps,
    output logic [31:0] fired_count,
    output logic [3:0]  trigger_union,
    output logic [63:0] accum_flux
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > 13) ? CNT_W : 13;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(TABLE_DEPTH);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_DRD  = 4'd2;
    localparam logic [3:0] S_MUL1 = 4'd3;
    localparam logic [3:0] S_MUL2 = 4'd4;
    localparam logic [3:0] S_MUL3 = 4'd5;
    localparam logic [3:0] S_MUL4 = 4'd6;
    localparam logic [3:0] S_MUL5 = 4'd7;
    localparam logic [3:0] S_BEG  = 4'd8;
    localparam logic [3:0] S_UPD  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    // control state
    logic [3:0]       state_reg, state_next;
    logic             enabled_reg;
    logic [15:0]      thr_reg;
    logic [12:0]      cap_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [47:0]      total_rate_reg, total_rate_next;
    logic [31:0]      step_time_reg, step_time_next;
    logic [63:0]      flag_flux_reg, flag_flux_next;
    logic [31:0]      fired_total_reg, fired_total_next;
    logic [CNT_W-1:0] scan_addr_reg, scan_addr_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             out_valid_reg, out_valid_next;

    // payload
    logic [1:0]       cmd_reg, cmd_next;
    hfr_pkg::key_t    key_reg, key_next;
    logic [7:0]       species_reg, species_next;
    logic [47:0]      origin_reg, origin_next;
    logic [47:0]      rate_reg, rate_next;
    logic [31:0]      dt_reg, dt_next;
    logic [31:0]      bar_reg, bar_next;
    logic [31:0]      lev_reg, lev_next;
    logic [3:0]       trig_reg, trig_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             ins_reg, ins_next;
    logic [63:0]      p_reg, p_next;
    logic [47:0]      q_reg, q_next;
    logic [47:0]      s1_reg, s1_next;
    logic [31:0]      s2_reg, s2_next;
    logic [63:0]      inc_reg, inc_next;
    logic [2:0]       res_status_reg, res_status_next;
    logic [11:0]      res_index_reg, res_index_next;
    logic [31:0]      res_steps_reg, res_steps_next;
    logic [31:0]      res_fired_reg, res_fired_next;
    logic [3:0]       res_trig_reg, res_trig_next;
    logic [63:0]      res_flux_reg, res_flux_next;
    logic [2:0]       out_status_reg, out_status_next;
    logic [11:0]      out_index_reg, out_index_next;
    logic [31:0]      out_steps_reg, out_steps_next;
    logic [31:0]      out_fired_reg, out_fired_next;
    logic [3:0]       out_trig_reg, out_trig_next;
    logic [63:0]      out_flux_reg, out_flux_next;

    // memory and multiplier hookup
    logic             key_re, key_we, data_re, data_we;
    logic [IDX_W-1:0] key_raddr;
    hfr_pkg::key_t    key_rdata;
    hfr_pkg::entry_t  data_rdata, data_wdata;
    logic [31:0]      mul_a, mul_b;
    logic [63:0]      mul_p;

    logic [15:0]      thr_eff;
    logic [CMP_W-1:0] cap_eff;
    logic [31:0]      dt_sel;
    logic             hit, in_acc, out_free;
    hfr_pkg::entry_t  old_e, new_e;
    logic [63:0]      thr_tot, rate_sh;
    logic [3:0]       trig_new;

    hfr_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_table (
        .clk        (clk),
        .key_re     (key_re),
        .key_raddr  (key_raddr),
        .key_rdata  (key_rdata),
        .key_we     (key_we),
        .key_waddr  (idx_reg),
        .key_wdata  (key_reg),
        .data_re    (data_re),
        .data_raddr (idx_reg),
        .data_rdata (data_rdata),
        .data_we    (data_we),
        .data_waddr (idx_reg),
        .data_wdata (data_wdata)
    );

    hfr_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign thr_eff = (thr_reg == 16'd0) ? hfr_pkg::THRESHOLD_DEF : thr_reg;
    assign cap_eff = (cap_reg == 13'd0 || CMP_W'(cap_reg) > DEPTH_C) ? DEPTH_C
                                                                      : CMP_W'(cap_reg);
    assign dt_sel  = (cmd_reg == hfr_pkg::CMD_BEGIN) ? dt_reg : step_time_reg;

    assign hit = rd_pend_reg && (key_rdata == key_reg);

    assign key_raddr = scan_addr_reg[IDX_W-1:0];
    assign key_re    = (state_reg == S_SCAN) && !hit && (scan_addr_reg < count_reg);
    assign key_we    = (state_reg == S_UPD) && ins_reg;
    assign data_re   = (state_reg == S_DRD);
    assign data_we   = (state_reg == S_UPD);

    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (state_reg)
            S_MUL1:
            begin
                mul_a = rate_reg[47:16];
                mul_b = dt_sel;
            end
            S_MUL2:
            begin
                mul_a = {16'd0, rate_reg[15:0]};
                mul_b = dt_sel;
            end
            S_MUL3:
            begin
                mul_a = {16'd0, thr_eff};
                mul_b = total_rate_reg[47:16];
            end
            S_MUL4:
            begin
                mul_a = {16'd0, thr_eff};
                mul_b = {16'd0, total_rate_reg[15:0]};
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    // entry update; a fresh insert starts from all zeros
    always_comb
    begin
        old_e   = ins_reg ? '0 : data_rdata;
        new_e   = old_e;
        thr_tot = {s1_reg, 16'd0} + {32'd0, s2_reg};
        rate_sh = {rate_reg, 16'd0};
        trig_new = trig_reg;
        trig_new[hfr_pkg::FLUX_BIT] = (total_rate_reg != 48'd0) && (rate_sh > thr_tot);
        if (cmd_reg == hfr_pkg::CMD_ENROLL)
        begin
            if (old_e.steps == 32'd0)
            begin
                new_e.origin  = origin_reg;
                new_e.species = species_reg;
            end
            new_e.steps    = hfr_pkg::sat_inc32(old_e.steps);
            new_e.flux     = hfr_pkg::sat_add64(old_e.flux, inc_reg);
            new_e.barrier  = bar_reg;
            new_e.leverage = lev_reg;
            new_e.triggers = old_e.triggers | trig_new;
        end
        else
        begin
            new_e.fired = hfr_pkg::sat_inc32(old_e.fired);
        end
        data_wdata = new_e;
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        total_rate_next  = total_rate_reg;
        step_time_next   = step_time_reg;
        flag_flux_next   = flag_flux_reg;
        fired_total_next = fired_total_reg;
        scan_addr_next   = scan_addr_reg;
        rd_pend_next     = rd_pend_reg;
        out_valid_next   = out_valid_reg && out_stall;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        species_next     = species_reg;
        origin_next      = origin_reg;
        rate_next        = rate_reg;
        dt_next          = dt_reg;
        bar_next         = bar_reg;
        lev_next         = lev_reg;
        trig_next        = trig_reg;
        rd_idx_next      = rd_idx_reg;
        idx_next         = idx_reg;
        ins_next         = ins_reg;
        p_next           = p_reg;
        q_next           = q_reg;
        s1_next          = s1_reg;
        s2_next          = s2_reg;
        inc_next         = inc_reg;
        res_status_next  = res_status_reg;
        res_index_next   = res_index_reg;
        res_steps_next   = res_steps_reg;
        res_fired_next   = res_fired_reg;
        res_trig_next    = res_trig_reg;
        res_flux_next    = res_flux_reg;
        out_status_next  = out_status_reg;
        out_index_next   = out_index_reg;
        out_steps_next   = out_steps_reg;
        out_fired_next   = out_fired_reg;
        out_trig_next    = out_trig_reg;
        out_flux_next    = out_flux_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    cmd_next           = cmd;
                    key_next.low_site  = (vacancy_site < partner_site) ? vacancy_site
                                                                       : partner_site;
                    key_next.high_site = (vacancy_site < partner_site) ? partner_site
                                                                       : vacancy_site;
                    key_next.dir       = dir_index;
                    species_next       = atom_species;
                    origin_next        = origin_coords;
                    rate_next          = rate;
                    dt_next            = step_dt;
                    bar_next           = barrier_estimate;
                    lev_next           = leverage_value;
                    trig_next          = trigger_bits;
                    scan_addr_next     = '0;
                    rd_pend_next       = 1'b0;
                    res_status_next    = hfr_pkg::ST_DISABLED;
                    res_index_next     = 12'd0;
                    res_steps_next     = 32'd0;
                    res_fired_next     = 32'd0;
                    res_trig_next      = 4'd0;
                    res_flux_next      = 64'd0;
                    if (!enabled_reg)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        case (cmd)
                            hfr_pkg::CMD_BEGIN:  state_next = S_MUL1;
                            hfr_pkg::CMD_ENROLL: state_next = S_SCAN;
                            hfr_pkg::CMD_FIRED:  state_next = S_SCAN;
                            default:             state_next = S_OUT;
                        endcase
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    idx_next   = rd_idx_reg;
                    ins_next   = 1'b0;
                    state_next = S_DRD;
                end
                else if (scan_addr_reg < count_reg)
                begin
                    rd_pend_next   = 1'b1;
                    rd_idx_next    = scan_addr_reg[IDX_W-1:0];
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
                else if (CMP_W'(count_reg) >= cap_eff)
                begin
                    if (cmd_reg == hfr_pkg::CMD_FIRED)
                    begin
                        fired_total_next = hfr_pkg::sat_inc32(fired_total_reg);
                    end
                    res_status_next = hfr_pkg::ST_FULL;
                    state_next      = S_OUT;
                end
                else
                begin
                    idx_next   = count_reg[IDX_W-1:0];
                    ins_next   = 1'b1;
                    state_next = S_DRD;
                end
            end
            S_DRD:  state_next = S_MUL1;
            S_MUL1: state_next = S_MUL2;
            S_MUL2:
            begin
                p_next     = mul_p;
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                q_next     = mul_p[47:0];
                state_next = S_MUL4;
            end
            S_MUL4:
            begin
                s1_next    = mul_p[47:0];
                inc_next   = hfr_pkg::flux_inc(p_reg, q_reg);
                state_next = (cmd_reg == hfr_pkg::CMD_BEGIN) ? S_BEG : S_MUL5;
            end
            S_MUL5:
            begin
                s2_next    = mul_p[31:0];
                state_next = S_UPD;
            end
            S_BEG:
            begin
                total_rate_next = rate_reg;
                step_time_next  = dt_reg;
                flag_flux_next  = hfr_pkg::sat_add64(flag_flux_reg, inc_reg);
                res_status_next = hfr_pkg::ST_BEGUN;
                state_next      = S_OUT;
            end
            S_UPD:
            begin
                if (ins_reg)
                begin
                    count_next = count_reg + 1'b1;
                end
                if (cmd_reg == hfr_pkg::CMD_FIRED)
                begin
                    fired_total_next = hfr_pkg::sat_inc32(fired_total_reg);
                end
                res_status_next = ins_reg ? hfr_pkg::ST_INSERTED : hfr_pkg::ST_UPDATED;
                res_index_next  = 12'(idx_reg);
                res_steps_next  = new_e.steps;
                res_fired_next  = new_e.fired;
                res_trig_next   = new_e.triggers;
                res_flux_next   = new_e.flux;
                state_next      = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_index_next  = res_index_reg;
                    out_steps_next  = res_steps_reg;
                    out_fired_next  = res_fired_reg;
                    out_trig_next   = res_trig_reg;
                    out_flux_next   = res_flux_reg;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            enabled_reg     <= 1'b0;
            thr_reg         <= hfr_pkg::THRESHOLD_DEF;
            cap_reg         <= hfr_pkg::CAPACITY_DEF;
            count_reg       <= '0;
            total_rate_reg  <= 48'd0;
            step_time_reg   <= 32'd0;
            flag_flux_reg   <= 64'd0;
            fired_total_reg <= 32'd0;
            scan_addr_reg   <= '0;
            rd_pend_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            total_rate_reg  <= total_rate_next;
            step_time_reg   <= step_time_next;
            flag_flux_reg   <= flag_flux_next;
            fired_total_reg <= fired_total_next;
            scan_addr_reg   <= scan_addr_next;
            rd_pend_reg     <= rd_pend_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    hfr_pkg::CFG_ENABLED:   enabled_reg <= cfg_data[0];
                    hfr_pkg::CFG_THRESHOLD: thr_reg     <= cfg_data;
                    hfr_pkg::CFG_CAPACITY:  cap_reg     <= cfg_data[12:0];
                    default:                ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        species_reg    <= species_next;
        origin_reg     <= origin_next;
        rate_reg       <= rate_next;
        dt_reg         <= dt_next;
        bar_reg        <= bar_next;
        lev_reg        <= lev_next;
        trig_reg       <= trig_next;
        rd_idx_reg     <= rd_idx_next;
        idx_reg        <= idx_next;
        ins_reg        <= ins_next;
        p_reg          <= p_next;
        q_reg          <= q_next;
        s1_reg         <= s1_next;
        s2_reg         <= s2_next;
        inc_reg        <= inc_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_steps_reg  <= res_steps_next;
        res_fired_reg  <= res_fired_next;
        res_trig_reg   <= res_trig_next;
        res_flux_reg   <= res_flux_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_steps_reg  <= out_steps_next;
        out_fired_reg  <= out_fired_next;
        out_trig_reg   <= out_trig_next;
        out_flux_reg   <= out_flux_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign entry_index    = out_index_reg;
    assign enrolled_steps = out_steps_reg;
    assign fired_count    = out_fired_reg;
    assign trigger_union  = out_trig_reg;
    assign accum_flux     = out_flux_reg;

endmodule

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         DEPTH      = hfr_pkg::TABLE_DEPTH_DEF;

    typedef struct {
        logic [1:0]         cmd;
        logic [23:0]        vac;
        logic [23:0]        neigh;
        logic [5:0]         dir;
        logic [7:0]         species;
        logic [47:0]        origin;
        logic [47:0]        rate;
        logic [31:0]        dt;
        logic signed [31:0] barrier;
        logic [31:0]        leverage;
        logic [3:0]         trig;
    } hop_item_t;

    typedef struct {
        logic [2:0]  status;
        logic [11:0] index;
        logic [31:0] steps;
        logic [31:0] fired;
        logic [3:0]  triggers;
        logic [63:0] flux;
    } hop_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = '0;
    logic [23:0] vacancy_site = '0;
    logic [23:0] partner_site = '0;
    logic [5:0]  dir_index = '0;
    logic [7:0]  atom_species = '0;
    logic [47:0] origin_coords = '0;
    logic [47:0] rate = '0;
    logic [31:0] step_dt = '0;
    logic signed [31:0] barrier_estimate = '0;
    logic [31:0] leverage_value = '0;
    logic [3:0]  trigger_bits = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [11:0] entry_index;
    logic [31:0] enrolled_steps;
    logic [31:0] fired_count;
    logic [3:0]  trigger_union;
    logic [63:0] accum_flux;

    hop_flag_registry u_top (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    logic            chan_on;
    logic [15:0]     share_thr;
    logic [12:0]     cap_val;
    int              n_entries;
    hfr_pkg::key_t   keys [DEPTH];
    hfr_pkg::entry_t entries [DEPTH];
    logic [47:0]     total_rate;
    logic [31:0]     cur_dt;

    hop_result_t expected_q [$];
    int          errors = 0;
    bit          calm = 0;
    logic [23:0] site_pool [8];

    function automatic logic [63:0] rate_dt(logic [47:0] r, logic [31:0] d);
        logic [79:0] prod;
        prod = {32'd0, r} * {48'd0, d};
        return {16'd0, prod[79:32]};
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    function automatic logic [31:0] inc_sat(logic [31:0] a);
        return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
    endfunction

    function automatic hop_result_t registry_update(hop_item_t it);
        hop_result_t   r;
        hfr_pkg::key_t k;
        int            e;
        int            cap;
        logic [15:0]   thr;
        logic [3:0]    t;
        r = '{default: '0};
        if (!chan_on || it.cmd == CMD_UNUSED)
        begin
            r.status = hfr_pkg::ST_DISABLED;
            return r;
        end
        if (it.cmd == hfr_pkg::CMD_BEGIN)
        begin
            total_rate = it.rate;
            cur_dt = it.dt;
            r.status = hfr_pkg::ST_BEGUN;
            return r;
        end
        k.low_site  = (it.vac < it.neigh) ? it.vac : it.neigh;
        k.high_site = (it.vac < it.neigh) ? it.neigh : it.vac;
        k.dir       = it.dir;
        e = -1;
        for (int i = 0; i < n_entries; i++)
        begin
            if (keys[i] == k)
            begin
                e = i;
                break;
            end
        end
        r.status = hfr_pkg::ST_UPDATED;
        if (e < 0)
        begin
            cap = (cap_val == 0 || cap_val > DEPTH) ? DEPTH : int'(cap_val);
            if (n_entries >= cap)
            begin
                r.status = hfr_pkg::ST_FULL;
                return r;
            end
            e = n_entries++;
            keys[e] = k;
            entries[e] = '0;
            r.status = hfr_pkg::ST_INSERTED;
        end
        if (it.cmd == hfr_pkg::CMD_ENROLL)
        begin
            thr = (share_thr != 0) ? share_thr : hfr_pkg::THRESHOLD_DEF;
            if (entries[e].steps == 0)
            begin
                entries[e].origin  = it.origin;
                entries[e].species = it.species;
            end
            entries[e].steps    = inc_sat(entries[e].steps);
            entries[e].flux     = add_sat(entries[e].flux, rate_dt(it.rate, cur_dt));
            entries[e].barrier  = it.barrier;
            entries[e].leverage = it.leverage;
            t = it.trig;
            t[hfr_pkg::FLUX_BIT] = (total_rate != 0) &&
                ({it.rate, 16'd0} > ({48'd0, thr} * {16'd0, total_rate}));
            entries[e].triggers |= t;
        end
        else
        begin
            entries[e].fired = inc_sat(entries[e].fired);
        end
        r.index    = e[11:0];
        r.steps    = entries[e].steps;
        r.fired    = entries[e].fired;
        r.triggers = entries[e].triggers;
        r.flux     = entries[e].flux;
        return r;
    endfunction

    always @(negedge clk)
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 35);

    always @(posedge clk)
    begin
        hop_result_t x;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result with nothing expected, status %0d", status);
                errors++;
            end
            else
            begin
                x = expected_q.pop_front();
                if (status !== x.status)
                begin
                    $error("status exp %0d got %0d", x.status, status);
                    errors++;
                end
                if (entry_index !== x.index)
                begin
                    $error("entry_index exp %0d got %0d", x.index, entry_index);
                    errors++;
                end
                if (enrolled_steps !== x.steps)
                begin
                    $error("enrolled_steps exp %0d got %0d", x.steps, enrolled_steps);
                    errors++;
                end
                if (fired_count !== x.fired)
                begin
                    $error("fired_count exp %0d got %0d", x.fired, fired_count);
                    errors++;
                end
                if (trigger_union !== x.triggers)
                begin
                    $error("trigger_union exp %h got %h", x.triggers, trigger_union);
                    errors++;
                end
                if (accum_flux !== x.flux)
                begin
                    $error("accum_flux exp %h got %h", x.flux, accum_flux);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(hop_item_t it);
        @(negedge clk);
        if (!calm)
        begin
            while ($urandom_range(99) < 35)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_valid         <= 1'b1;
        cmd              <= it.cmd;
        vacancy_site     <= it.vac;
        partner_site     <= it.neigh;
        dir_index        <= it.dir;
        atom_species     <= it.species;
        origin_coords    <= it.origin;
        rate             <= it.rate;
        step_dt          <= it.dt;
        barrier_estimate <= it.barrier;
        leverage_value   <= it.leverage;
        trigger_bits     <= it.trig;
        do
            @(posedge clk);
        while (in_stall);
        expected_q.push_back(registry_update(it));
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            hfr_pkg::CFG_ENABLED:   chan_on = val[0];
            hfr_pkg::CFG_THRESHOLD: share_thr = val;
            hfr_pkg::CFG_CAPACITY:  cap_val = val[12:0];
            default: ;
        endcase
    endtask

    function automatic hop_item_t make_item(logic [1:0] c, logic [23:0] a, logic [23:0] b,
                                            logic [5:0] d, logic [47:0] r, logic [31:0] t);
        hop_item_t it;
        it.cmd      = c;
        it.vac      = a;
        it.neigh    = b;
        it.dir      = d;
        it.species  = 8'($urandom);
        it.origin   = 48'({$urandom, $urandom});
        it.rate     = r;
        it.dt       = t;
        it.barrier  = $urandom;
        it.leverage = $urandom;
        it.trig     = 4'($urandom);
        return it;
    endfunction

    function automatic logic [23:0] pick_site();
        return ($urandom_range(9) < 8) ? site_pool[$urandom_range(7)] : 24'($urandom);
    endfunction

    function automatic hop_item_t random_item();
        int          sel;
        logic [1:0]  c;
        logic [47:0] r;
        sel = $urandom_range(99);
        c = (sel < 15) ? hfr_pkg::CMD_BEGIN : (sel < 65) ? hfr_pkg::CMD_ENROLL
            : (sel < 97) ? hfr_pkg::CMD_FIRED : CMD_UNUSED;
        case ($urandom_range(3))
            0:       r = 48'({$urandom, $urandom});
            1:       r = 48'($urandom_range(65535));
            default: r = {16'd0, $urandom};
        endcase
        return make_item(c, pick_site(), pick_site(), $urandom_range(3) == 0 ? 6'($urandom)
                         : 6'($urandom_range(1)), r, $urandom);
    endfunction

    task automatic test_disabled();
        send_item(make_item(hfr_pkg::CMD_ENROLL, 24'd5, 24'd9, 6'd1, 48'd100, 32'd0));
        send_item(make_item(hfr_pkg::CMD_BEGIN, 24'd0, 24'd0, 6'd0, 48'd7, 32'd7));
        drain();
        write_reg(hfr_pkg::CFG_ENABLED, 16'd1);
        send_item(make_item(CMD_UNUSED, 24'd5, 24'd9, 6'd1, 48'd100, 32'd0));
    endtask

    task automatic test_steps_and_entries();
        // enroll before any step: zero total rate clears the flux trigger
        send_item(make_item(hfr_pkg::CMD_ENROLL, 24'hFFFFFF, 24'd0, 6'd63, {48{1'b1}},
                            32'd0));
        send_item(make_item(hfr_pkg::CMD_BEGIN, 24'd0, 24'd0, 6'd0, {48{1'b1}},
                            32'hFFFF_FFFF));
        send_item(make_item(hfr_pkg::CMD_ENROLL, 24'd0, 24'hFFFFFF, 6'd63, {48{1'b1}},
                            32'd0));
        send_item(make_item(hfr_pkg::CMD_ENROLL, 24'd0, 24'hFFFFFF, 6'd0, 48'd1, 32'd0));
        // fired first, enrolled afterwards
        send_item(make_item(hfr_pkg::CMD_FIRED, 24'd40, 24'd30, 6'd2, 48'd0, 32'd0));
        send_item(make_item(hfr_pkg::CMD_ENROLL, 24'd30, 24'd40, 6'd2, 48'h1_0000, 32'd0));
        send_item(make_item(hfr_pkg::CMD_FIRED, 24'd30, 24'd40, 6'd2, 48'd0, 32'd0));
        send_item(make_item(hfr_pkg::CMD_BEGIN, 24'd0, 24'd0, 6'd0, 48'd0, 32'd1));
        send_item(make_item(hfr_pkg::CMD_ENROLL, 24'd30, 24'd40, 6'd2, {48{1'b1}}, 32'd0));
    endtask

    task automatic test_threshold();
        drain();
        write_reg(hfr_pkg::CFG_THRESHOLD, 16'd0);
        send_item(make_item(hfr_pkg::CMD_BEGIN, 24'd0, 24'd0, 6'd0, 48'd100_000,
                            32'h8000_0000));
        send_item(make_item(hfr_pkg::CMD_ENROLL, 24'd1, 24'd2, 6'd3, 48'd1000, 32'd0));
        send_item(make_item(hfr_pkg::CMD_ENROLL, 24'd1, 24'd2, 6'd3, 48'd1001, 32'd0));
        drain();
        write_reg(hfr_pkg::CFG_THRESHOLD, 16'hFFFF);
        send_item(make_item(hfr_pkg::CMD_ENROLL, 24'd2, 24'd1, 6'd3, 48'd99_999, 32'd0));
        send_item(make_item(hfr_pkg::CMD_ENROLL, 24'd2, 24'd1, 6'd3, 48'd100_000, 32'd0));
        drain();
        write_reg(hfr_pkg::CFG_THRESHOLD, hfr_pkg::THRESHOLD_DEF);
    endtask

    task automatic test_table_full();
        drain();
        write_reg(hfr_pkg::CFG_CAPACITY, 16'd1);
        send_item(make_item(hfr_pkg::CMD_ENROLL, 24'd77, 24'd78, 6'd5, 48'd5, 32'd0));
        send_item(make_item(hfr_pkg::CMD_FIRED, 24'd77, 24'd78, 6'd5, 48'd5, 32'd0));
        send_item(make_item(hfr_pkg::CMD_ENROLL, 24'd40, 24'd30, 6'd2, 48'd5, 32'd0));
        drain();
        write_reg(hfr_pkg::CFG_CAPACITY, 16'h1FFF);
        send_item(make_item(hfr_pkg::CMD_FIRED, 24'd77, 24'd78, 6'd5, 48'd5, 32'd0));
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            calm = (i >= count / 2) && (i < count / 2 + 30);
            send_item(random_item());
            if (i == count / 3)
            begin
                drain();
                write_reg(hfr_pkg::CFG_CAPACITY, 16'd0);
                write_reg(hfr_pkg::CFG_THRESHOLD, 16'($urandom));
            end
            if (i == 2 * count / 3)
            begin
                drain();
                write_reg(hfr_pkg::CFG_CAPACITY, {3'd0, hfr_pkg::CAPACITY_DEF});
            end
        end
        calm = 0;
    endtask

    initial
    begin
        chan_on = 1'b0;
        share_thr = hfr_pkg::THRESHOLD_DEF;
        cap_val = hfr_pkg::CAPACITY_DEF;
        n_entries = 0;
        total_rate = '0;
        cur_dt = '0;
        site_pool[0] = 24'd0;
        site_pool[1] = 24'hFFFFFF;
        for (int i = 2; i < 8; i++)
            site_pool[i] = 24'($urandom);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_disabled();
        test_steps_and_entries();
        test_threshold();
        test_table_full();
        test_random(120);
        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule
